### rtl/core/iahar_pkg.sv
// Shared widths, register indexes, config bundle and fixed-point helpers.
`timescale 1ns / 1ps

package iahar_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int FRAC_BITS   = 12;
  localparam int MAG_WIDTH   = VALUE_WIDTH - 1;
  localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
  localparam int IDX_WIDTH   = 3;

  localparam logic [MAG_WIDTH-1:0] MAXV = '1;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_GAIN            = 3'd0,
    REG_RATE_LIMIT      = 3'd1,
    REG_RATE_FLOOR      = 3'd2,
    REG_ANGLE_TOLERANCE = 3'd3,
    REG_ACTUATION_LAG   = 3'd4,
    REG_HALF_INV_DECEL  = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] gain;
    logic [MAG_WIDTH-1:0]   rate_limit;
    logic [MAG_WIDTH-1:0]   rate_floor;
    logic [MAG_WIDTH-1:0]   angle_tolerance;
    logic [VALUE_WIDTH-1:0] actuation_lag;
    logic [VALUE_WIDTH-1:0] half_inv_decel;
  } cfg_t;

  // Unsigned fixed-point product, floored, saturated to MAXV.
  function automatic logic [MAG_WIDTH-1:0] fx_mul(input logic [VALUE_WIDTH-1:0] a,
                                                  input logic [VALUE_WIDTH-1:0] b);
    logic [PROD_WIDTH-1:0] prod;
    logic [PROD_WIDTH-1:0] shifted;
    prod    = a * b;
    shifted = prod >> FRAC_BITS;
    if (shifted[PROD_WIDTH-1:MAG_WIDTH] != '0) begin
      return MAXV;
    end
    return shifted[MAG_WIDTH-1:0];
  endfunction

  // Symmetric saturation of a one-bit-wider signed value.
  function automatic logic signed [VALUE_WIDTH-1:0] sat_sym(
      input logic signed [VALUE_WIDTH:0] v);
    logic signed [VALUE_WIDTH:0] pos;
    logic signed [VALUE_WIDTH:0] neg;
    pos = signed'({2'b00, MAXV});
    neg = -pos;
    if (v > pos) begin
      return pos[VALUE_WIDTH-1:0];
    end
    if (v < neg) begin
      return neg[VALUE_WIDTH-1:0];
    end
    return v[VALUE_WIDTH-1:0];
  endfunction

endpackage

### rtl/core/iahar_pipe.sv
// Seven-stage datapath: coast prediction, predicted error, gain and clamp.
`timescale 1ns / 1ps

module iahar_pipe
  import iahar_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          in_valid,
  input  logic signed [VALUE_WIDTH-1:0] heading_error,
  input  logic signed [VALUE_WIDTH-1:0] yaw_rate,
  output logic                          out_valid,
  output logic signed [VALUE_WIDTH-1:0] rate_command
);

  // stage valids
  logic [6:0] vld;

  // stage 1: saturated inputs, |wz|
  logic signed [VALUE_WIDTH-1:0] e1;
  logic [MAG_WIDTH-1:0]          w1;
  logic                          wzpos1, wznz1;
  // stage 2: lin, wz^2
  logic signed [VALUE_WIDTH-1:0] e2;
  logic [MAG_WIDTH-1:0]          lin2, sq2;
  logic                          wzpos2, wznz2;
  // stage 3: quad
  logic signed [VALUE_WIDTH-1:0] e3;
  logic [MAG_WIDTH-1:0]          lin3, quad3;
  logic                          wzpos3, wznz3;
  // stage 4: coast angle
  logic signed [VALUE_WIDTH-1:0] e4;
  logic [MAG_WIDTH-1:0]          coast4;
  logic                          wzpos4;
  // stage 5: predicted error magnitude and decision
  logic [MAG_WIDTH-1:0]          mag5;
  logic                          neg5, act5;
  // stage 6: gain product
  logic [MAG_WIDTH-1:0]          m6;
  logic                          neg6, act6;

  logic signed [VALUE_WIDTH-1:0] e_in, wz_in;
  logic [MAG_WIDTH:0]            coast_sum;
  logic signed [VALUE_WIDTH:0]   ep_wide;
  logic signed [VALUE_WIDTH-1:0] ep;
  logic [VALUE_WIDTH-1:0]        ep_abs;
  logic [MAG_WIDTH-1:0]          m_floor, m_clamp;

  always_comb begin
    e_in  = sat_sym({heading_error[VALUE_WIDTH-1], heading_error});
    wz_in = sat_sym({yaw_rate[VALUE_WIDTH-1], yaw_rate});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:0], in_valid};
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    e1     <= e_in;
    w1     <= wz_in[VALUE_WIDTH-1] ? MAG_WIDTH'(-wz_in) : wz_in[MAG_WIDTH-1:0];
    wzpos1 <= !wz_in[VALUE_WIDTH-1] && (wz_in != '0);
    wznz1  <= (wz_in != '0);
  end

  // stage 2
  always_ff @(posedge clk) begin
    e2     <= e1;
    lin2   <= fx_mul({1'b0, w1}, cfg.actuation_lag);
    sq2    <= fx_mul({1'b0, w1}, {1'b0, w1});
    wzpos2 <= wzpos1;
    wznz2  <= wznz1;
  end

  // stage 3
  always_ff @(posedge clk) begin
    e3     <= e2;
    lin3   <= lin2;
    quad3  <= fx_mul({1'b0, sq2}, cfg.half_inv_decel);
    wzpos3 <= wzpos2;
    wznz3  <= wznz2;
  end

  // stage 4: no coasting when the decel term is off or wz is zero
  always_comb begin
    coast_sum = {1'b0, lin3} + {1'b0, quad3};
  end

  always_ff @(posedge clk) begin
    e4     <= e3;
    wzpos4 <= wzpos3;
    if (cfg.half_inv_decel == '0 || !wznz3) begin
      coast4 <= '0;
    end else if (coast_sum[MAG_WIDTH]) begin
      coast4 <= MAXV;
    end else begin
      coast4 <= coast_sum[MAG_WIDTH-1:0];
    end
  end

  // stage 5: e_pred = e -/+ coast, in the direction of wz
  always_comb begin
    if (wzpos4) begin
      ep_wide = {e4[VALUE_WIDTH-1], e4} - signed'({2'b00, coast4});
    end else begin
      ep_wide = {e4[VALUE_WIDTH-1], e4} + signed'({2'b00, coast4});
    end
    ep     = (coast4 != '0) ? sat_sym(ep_wide) : e4;
    ep_abs = ep[VALUE_WIDTH-1] ? VALUE_WIDTH'(-ep) : VALUE_WIDTH'(ep);
  end

  always_ff @(posedge clk) begin
    mag5 <= ep_abs[MAG_WIDTH-1:0];
    neg5 <= ep[VALUE_WIDTH-1];
    act5 <= (ep_abs[MAG_WIDTH-1:0] > cfg.angle_tolerance) &&
            (((ep > 0) && (e4 > 0)) || ((ep < 0) && (e4 < 0)));
  end

  // stage 6
  always_ff @(posedge clk) begin
    m6   <= fx_mul(cfg.gain, {1'b0, mag5});
    neg6 <= neg5;
    act6 <= act5;
  end

  // stage 7: floor, then limit (limit wins)
  always_comb begin
    m_floor = (m6 < cfg.rate_floor) ? cfg.rate_floor : m6;
    m_clamp = (m_floor > cfg.rate_limit) ? cfg.rate_limit : m_floor;
  end

  always_ff @(posedge clk) begin
    if (!act6) begin
      rate_command <= '0;
    end else if (neg6) begin
      rate_command <= -signed'({1'b0, m_clamp});
    end else begin
      rate_command <= signed'({1'b0, m_clamp});
    end
  end

  assign out_valid = vld[6];

endmodule

### rtl/core/inertia_aware_heading_align_rate_top.sv
// Top level: configuration registers, command handshake and datapath.
`timescale 1ns / 1ps

// Heading-align yaw-rate command with coast prediction. A sample transfer
// happens at each rising edge with start high (busy is always low), so one
// heading_error/yaw_rate pair may enter every cycle. The first stage captures
// the sample at its start edge. The result appears on rate_command with done
// high once the sample has passed the seven-stage datapath: input saturation,
// two multiplier stages for the coast angle, coast sum, predicted error, gain
// multiply and clamp. done is a one-cycle strobe. The receiver cannot stall it
// and must capture rate_command in that cycle. Results leave in input order.
// Registers are written through cfg_valid/cfg_ready (ready always high);
// unknown indexes are dropped. Write them only while no sample is in flight.
module inertia_aware_heading_align_rate_top
  import iahar_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] heading_error,
  input  logic signed [VALUE_WIDTH-1:0] yaw_rate,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] rate_command,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [IDX_WIDTH-1:0]          cfg_index,
  input  logic [VALUE_WIDTH-1:0]        cfg_data
);

  cfg_t cfg;

  // Fully pipelined, nothing ever holds the input off.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Register file; narrow registers keep the low bits of the write data.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain            <= 16'd4096;
      cfg.rate_limit      <= 15'd4096;
      cfg.rate_floor      <= '0;
      cfg.angle_tolerance <= 15'd41;
      cfg.actuation_lag   <= '0;
      cfg.half_inv_decel  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_GAIN:            cfg.gain            <= cfg_data;
        REG_RATE_LIMIT:      cfg.rate_limit      <= cfg_data[MAG_WIDTH-1:0];
        REG_RATE_FLOOR:      cfg.rate_floor      <= cfg_data[MAG_WIDTH-1:0];
        REG_ANGLE_TOLERANCE: cfg.angle_tolerance <= cfg_data[MAG_WIDTH-1:0];
        REG_ACTUATION_LAG:   cfg.actuation_lag   <= cfg_data;
        REG_HALF_INV_DECEL:  cfg.half_inv_decel  <= cfg_data;
        default: ;
      endcase
    end
  end

  iahar_pipe u_pipe (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (start && !busy),
    .heading_error (heading_error),
    .yaw_rate      (yaw_rate),
    .out_valid     (done),
    .rate_command  (rate_command)
  );

endmodule

### sim/tb.sv
// Self-checking testbench for the coast-aware heading-align yaw-rate block.
`timescale 1ns / 1ps

module tb;
  import iahar_pkg::*;

  // Pipeline depth in stages; wait_for_results idles past it before register writes.
  localparam int PIPE_LATENCY   = 7;
  // Cycles without any transfer before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_SAMPLES  = 100;
  localparam int REPORT_LIMIT   = 10;

  // Largest magnitude any internal value may take; everything clips here.
  localparam longint FULL_SCALE = (longint'(1) << (VALUE_WIDTH - 1)) - 1;

  // Register values after reset.
  localparam logic [VALUE_WIDTH-1:0] RST_GAIN      = 16'd4096;
  localparam logic [MAG_WIDTH-1:0]   RST_RATE_LIMIT = 15'd4096;
  localparam logic [MAG_WIDTH-1:0]   RST_RATE_FLOOR = 15'd0;
  localparam logic [MAG_WIDTH-1:0]   RST_TOLERANCE  = 15'd41;

  // Indexes outside the register map; writes to them must be dropped.
  localparam logic [IDX_WIDTH-1:0] UNUSED_INDEX_A = 3'd6;
  localparam logic [IDX_WIDTH-1:0] UNUSED_INDEX_B = 3'd7;

  typedef struct {
    logic signed [VALUE_WIDTH-1:0] heading;
    logic signed [VALUE_WIDTH-1:0] yaw;
    logic signed [VALUE_WIDTH-1:0] rate;
  } rate_expect_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic signed [VALUE_WIDTH-1:0] heading_error = '0;
  logic signed [VALUE_WIDTH-1:0] yaw_rate = '0;
  logic                          done;
  logic signed [VALUE_WIDTH-1:0] rate_command;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [IDX_WIDTH-1:0]          cfg_index = '0;
  logic [VALUE_WIDTH-1:0]        cfg_data = '0;

  // Shadow copy of the register file, updated on each config transfer.
  cfg_t         shadow_cfg;
  rate_expect_t pending_rates[$];
  rate_expect_t oldest;
  int           mismatch_count = 0;
  int           stall_cycles = 0;
  // Set for the stretch of stimulus where the sender never idles.
  bit           no_gaps = 1'b0;

  inertia_aware_heading_align_rate_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .heading_error (heading_error),
    .yaw_rate      (yaw_rate),
    .done          (done),
    .rate_command  (rate_command),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic longint clip_sym(input longint v);
    if (v > FULL_SCALE) return FULL_SCALE;
    if (v < -FULL_SCALE) return -FULL_SCALE;
    return v;
  endfunction

  // Non-negative Q-format product, floored by the shift, clipped.
  function automatic longint scaled_product(input longint a, input longint b);
    longint p;
    p = (a * b) >>> FRAC_BITS;
    return (p > FULL_SCALE) ? FULL_SCALE : p;
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] predict_rate(
      input logic signed [VALUE_WIDTH-1:0] err_raw,
      input logic signed [VALUE_WIDTH-1:0] yaw_raw);
    longint err, yaw, spin, coast, err_ahead, mag, cmd;
    longint gain_q, limit_q, floor_q, tol_q, lag_q, hid_q;
    gain_q  = shadow_cfg.gain;
    limit_q = shadow_cfg.rate_limit;
    floor_q = shadow_cfg.rate_floor;
    tol_q   = shadow_cfg.angle_tolerance;
    lag_q   = shadow_cfg.actuation_lag;
    hid_q   = shadow_cfg.half_inv_decel;
    // Most negative codes fold onto -FULL_SCALE first.
    err   = clip_sym(longint'(err_raw));
    yaw   = clip_sym(longint'(yaw_raw));
    coast = 0;
    if (hid_q != 0 && yaw != 0) begin
      spin  = (yaw < 0) ? -yaw : yaw;
      coast = scaled_product(spin, lag_q) +
              scaled_product(scaled_product(spin, spin), hid_q);
      if (coast > FULL_SCALE) coast = FULL_SCALE;
    end
    // Coast angle is taken off in the direction the body is turning.
    err_ahead = err;
    if (coast > 0) begin
      err_ahead = clip_sym((yaw > 0) ? err - coast : err + coast);
    end
    mag = (err_ahead < 0) ? -err_ahead : err_ahead;
    cmd = 0;
    // Overshoot (sign flip) or inside the tolerance band: hold still.
    if (mag > tol_q && ((err_ahead > 0 && err > 0) || (err_ahead < 0 && err < 0))) begin
      mag = scaled_product(gain_q, mag);
      if (mag < floor_q) mag = floor_q;
      if (mag > limit_q) mag = limit_q;
      if (mag > FULL_SCALE) mag = FULL_SCALE;
      cmd = (err_ahead >= 0) ? mag : -mag;
    end
    return cmd[VALUE_WIDTH-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: checks each result against the oldest prediction, then
  // records the prediction for a sample accepted at this edge and tracks
  // register writes. Each result is delayed by the pipeline registers, so
  // checking first never pops a prediction made at the same edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      shadow_cfg.gain            = RST_GAIN;
      shadow_cfg.rate_limit      = RST_RATE_LIMIT;
      shadow_cfg.rate_floor      = RST_RATE_FLOOR;
      shadow_cfg.angle_tolerance = RST_TOLERANCE;
      shadow_cfg.actuation_lag   = '0;
      shadow_cfg.half_inv_decel  = '0;
      pending_rates.delete();
    end else begin
      if (done) begin
        if (pending_rates.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected result rate_command=%0d", $realtime, rate_command);
        end else begin
          oldest = pending_rates.pop_front();
          if (rate_command !== oldest.rate) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: rate_command error e=%0d wz=%0d expected %0d got %0d",
                       $realtime, oldest.heading, oldest.yaw, oldest.rate, rate_command);
          end
        end
      end
      if (start && !busy)
        pending_rates.push_back('{heading_error, yaw_rate,
                                  predict_rate(heading_error, yaw_rate)});
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN:            shadow_cfg.gain = cfg_data;
          REG_RATE_LIMIT:      shadow_cfg.rate_limit = cfg_data[MAG_WIDTH-1:0];
          REG_RATE_FLOOR:      shadow_cfg.rate_floor = cfg_data[MAG_WIDTH-1:0];
          REG_ANGLE_TOLERANCE: shadow_cfg.angle_tolerance = cfg_data[MAG_WIDTH-1:0];
          REG_ACTUATION_LAG:   shadow_cfg.actuation_lag = cfg_data;
          REG_HALF_INV_DECEL:  shadow_cfg.half_inv_decel = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Idle cycles drawn one at a time (about 32 in 100), then one sample
  // transfer. start stays high on return so back-to-back samples go in on
  // consecutive edges.
  task automatic send_sample(input logic signed [VALUE_WIDTH-1:0] err,
                             input logic signed [VALUE_WIDTH-1:0] yaw);
    while (!no_gaps && $urandom_range(99) < 32) begin
      start <= 1'b0;
      @(posedge clk);
    end
    heading_error <= err;
    yaw_rate      <= yaw;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Sender holds off until every predicted result has come back, then
  // lets the pipeline settle so registers can be written safely.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_rates.size() != 0);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_WIDTH-1:0] idx,
                           input logic [VALUE_WIDTH-1:0] data);
    while ($urandom_range(99) < 32) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Full register load plus one write to an unmapped index.
  task automatic load_registers(input logic [VALUE_WIDTH-1:0] gain_v,
                                input logic [VALUE_WIDTH-1:0] limit_v,
                                input logic [VALUE_WIDTH-1:0] floor_v,
                                input logic [VALUE_WIDTH-1:0] tol_v,
                                input logic [VALUE_WIDTH-1:0] lag_v,
                                input logic [VALUE_WIDTH-1:0] hid_v);
    write_reg(REG_GAIN, gain_v);
    write_reg(REG_RATE_LIMIT, limit_v);
    write_reg($urandom_range(1) ? UNUSED_INDEX_A : UNUSED_INDEX_B, 16'($urandom));
    write_reg(REG_RATE_FLOOR, floor_v);
    write_reg(REG_ANGLE_TOLERANCE, tol_v);
    write_reg(REG_ACTUATION_LAG, lag_v);
    write_reg(REG_HALF_INV_DECEL, hid_v);
    cfg_valid <= 1'b0;
  endtask

  // Random value with a random number of significant bits, so small and
  // large magnitudes both show up often.
  function automatic logic [VALUE_WIDTH-1:0] spread_value(input int max_bits);
    logic [31:0] raw;
    raw = $urandom;
    return VALUE_WIDTH'(raw & ((32'd1 << $urandom_range(1, max_bits)) - 1));
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] random_field();
    logic signed [VALUE_WIDTH-1:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0: v = 16'sh8000;
          1: v = 16'sh8001;
          2: v = 16'sh7FFF;
          3: v = 16'sh0001;
          4: v = 16'shFFFF;
          default: v = '0;
        endcase
      end
      1: v = 16'($urandom);
      default: begin
        v = spread_value(VALUE_WIDTH - 1);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset registers: no coast, tolerance band edges, most negative codes.
  task automatic test_reset_config();
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd41, 16'sd0);
    send_sample(16'sd42, 16'sd100);
    send_sample(-16'sd42, -16'sd100);
    send_sample(16'sh8000, 16'sd5);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sd4096, 16'sd0);
    wait_for_results();
  endtask

  task automatic test_coast_cases();
    load_registers(16'd8192, 16'h7FFF, 16'd0, 16'd0, 16'd4096, 16'd2048);
    send_sample(16'sd8192, 16'sd2048);     // coast trims the error
    send_sample(-16'sd8192, -16'sd2048);   // mirrored
    send_sample(16'sd1000, 16'sd4096);     // coast overshoots: sign flip
    send_sample(-16'sd32767, 16'sh7FFF);   // coast and e_pred both clip
    send_sample(16'sh7FFF, 16'sh8000);     // most negative yaw rate
    send_sample(16'sd300, 16'sd1);         // quadratic term floors to zero
    send_sample(16'sd0, 16'sd5000);        // zero error
    wait_for_results();
  endtask

  // Floor above limit, lag without deceleration term, all-ones registers, minimal deceleration term.
  task automatic test_limits();
    load_registers(16'd4096, 16'd100, 16'd20000, 16'd10, 16'd4096, 16'd0);
    send_sample(16'sd50, 16'sd1000);
    send_sample(-16'sd11, -16'sd3000);
    send_sample(-16'sd5, 16'sd0);
    wait_for_results();
    load_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'sh8000, 16'sh8000);
    wait_for_results();
    load_registers(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd1);
    send_sample(16'sh7FFF, 16'sd3);
    send_sample(16'sh8000, -16'sd3);
    wait_for_results();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: load_registers('0, '0, '0, '0, '0, '0);
        1: load_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, spread_value(8),
                          16'hFFFF, 16'hFFFF);
        default: load_registers(spread_value(16), 16'($urandom_range(16'hFFFF)),
                                spread_value(14), spread_value(10),
                                spread_value(16), spread_value(16));
      endcase
      // One phase runs flat out with the sender never idling.
      no_gaps = (p == 3);
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        send_sample(random_field(), random_field());
        if (!no_gaps && $urandom_range(49) == 0) wait_for_results();
      end
      no_gaps = 1'b0;
      wait_for_results();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_config();
    test_coast_cases();
    test_limits();
    test_random_phases();
    if (mismatch_count == 0 && pending_rates.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
